[design/mtf_pkg.sv]
// ---------------------------------------------------------------------------
// mtf_pkg: shared types and constants of the move-to-front coder
// Holds the symbol width, the reduction group size, the sequencer states
// and the control bundle that the top level broadcasts to every cell.
// ---------------------------------------------------------------------------
package mtf_pkg;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned GROUP_SIZE = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_FINAL,
    S_MOVE
  } mtf_state_e;

  // Broadcast control for the row of list cells
  typedef struct packed {
    logic             load_identity;
    logic             shift;
    logic             decode_mode;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] pos;
  } mtf_ctrl_t;

endpackage

[design/move_to_front_coder.sv]
// ---------------------------------------------------------------------------
// move_to_front_coder: move-to-front coder over a row of list cells
// Encode turns bytes into ranks, decode turns ranks into bytes; the matched
// entry then moves to the front while the entries ahead shift back one cell.
// Each input byte passes through accept, compare, two OR-tree levels of the
// registered match reduction, and shift before the next byte is accepted;
// the shift waits while an earlier result still sits unaccepted in the
// output register.
// Reset: the list returns to identity order at once and decode_mode to 0.
// ---------------------------------------------------------------------------
module move_to_front_coder #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_data_i,     // [0] decode_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol_in
  input  logic [0:0] s_axis_tuser,   // [0] restart
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] symbol_out
);
  import mtf_pkg::*;

  localparam int unsigned GROUPS = (ALPHABET_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned PAD    = GROUPS * GROUP_SIZE;

  mtf_state_e       state_q, state_d;
  logic             decode_q;
  logic [SYM_W-1:0] sym_q;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] out_data_q, out_data_d;
  logic             in_beat, slot_free, do_move;
  logic             found;
  logic [SYM_W-1:0] pos, held;
  mtf_ctrl_t        ctrl;
  logic [PAD-1:0]   hit;
  logic [SYM_W-1:0] value [PAD];

  assign cfg_ready_o = 1'b1;
  assign in_beat     = s_axis_tvalid && s_axis_tready;
  assign slot_free   = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_beat) state_d = S_MATCH;
      S_MATCH: state_d = S_GROUP;
      S_GROUP: state_d = S_FINAL;
      S_FINAL: state_d = S_MOVE;
      S_MOVE:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    do_move       = 1'b0;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_MOVE:  do_move = slot_free;
      default: begin
        s_axis_tready = 1'b0;
        do_move       = 1'b0;
      end
    endcase
  end

  // Broadcast to the cells
  always_comb begin
    ctrl.load_identity = in_beat && s_axis_tuser[0];
    ctrl.shift         = do_move && found;
    ctrl.decode_mode   = decode_q;
    ctrl.sym           = sym_q;
    ctrl.pos           = pos;
  end

  // Output register: load the result, drop it once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (do_move) begin
      out_valid_d = 1'b1;
      out_data_d  = !found ? '0 : (decode_q ? held : pos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      decode_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        decode_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_beat) begin
      sym_q <= s_axis_tdata;
    end
  end

  // Row of list cells, padded with idle slots up to whole groups
  for (genvar i = 0; i < PAD; i++) begin : g_cell
    if (i < ALPHABET_SIZE) begin : g_live
      logic [SYM_W-1:0] left;
      if (i == 0) begin : g_head
        assign left = held;
      end else begin : g_body
        assign left = value[i-1];
      end
      mtf_cell #(
        .INDEX(i)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .left_i (left),
        .value_o(value[i]),
        .hit_o  (hit[i])
      );
    end else begin : g_pad
      assign value[i] = '0;
      assign hit[i]   = 1'b0;
    end
  end

  mtf_reduce #(
    .GROUPS(GROUPS)
  ) u_reduce (
    .clk_i  (clk_i),
    .hit_i  (hit),
    .value_i(value),
    .found_o(found),
    .pos_o  (pos),
    .held_o (held)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The list is a permutation, so at most one cell can match
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GROUP) |-> $onehot0(hit))
    else $error("more than one list cell matched");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_MATCH))
    else $error("accepted beat did not start a search");

  a_move_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_move |=> m_axis_tvalid)
    else $error("result not offered after move");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_move && !found) |=> (m_axis_tdata == '0))
    else $error("missed symbol gave nonzero result");

  a_no_shift_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.shift) |-> (state_q == S_MOVE && !ctrl.load_identity))
    else $error("list shifted outside the move step");

endmodule

[design/mtf_cell.sv]
// ---------------------------------------------------------------------------
// mtf_cell: one entry of the order list
// Holds one byte, flags a match against the current symbol, and takes the
// value of its left neighbor when the list moves an entry at or behind it to the front.
// ---------------------------------------------------------------------------
module mtf_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mtf_pkg::mtf_ctrl_t        ctrl_i,
  input  logic [mtf_pkg::SYM_W-1:0] left_i,
  output logic [mtf_pkg::SYM_W-1:0] value_o,
  output logic                      hit_o
);
  import mtf_pkg::*;

  localparam logic [SYM_W-1:0] Idx = SYM_W'(INDEX);

  logic [SYM_W-1:0] value_q, value_d;
  logic             hit_q, hit_d;
  logic             in_span;

  // Cells at or ahead of the moved entry take part in the shift
  assign in_span = (Idx <= ctrl_i.pos);

  // Select the next entry value
  always_comb begin
    value_d = value_q;
    if (ctrl_i.load_identity) begin
      value_d = Idx;
    end else if (ctrl_i.shift && in_span) begin
      value_d = left_i;
    end
  end

  // Compare by position in decode mode, by content in encode mode
  assign hit_d = ctrl_i.decode_mode ? (ctrl_i.sym == Idx) : (ctrl_i.sym == value_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= Idx;
      hit_q   <= 1'b0;
    end else begin
      value_q <= value_d;
      hit_q   <= hit_d;
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

[design/mtf_reduce.sv]
// ---------------------------------------------------------------------------
// mtf_reduce: registered two-level OR tree over the cell match flags
// Collapses the single matching cell into its position and its value,
// first per group of cells, then across the groups.
// ---------------------------------------------------------------------------
module mtf_reduce #(
  parameter int unsigned GROUPS = 16
) (
  input  logic                      clk_i,
  input  logic [GROUPS*mtf_pkg::GROUP_SIZE-1:0] hit_i,
  input  logic [mtf_pkg::SYM_W-1:0] value_i [GROUPS*mtf_pkg::GROUP_SIZE],
  output logic                      found_o,
  output logic [mtf_pkg::SYM_W-1:0] pos_o,
  output logic [mtf_pkg::SYM_W-1:0] held_o
);
  import mtf_pkg::*;

  logic [GROUPS-1:0] grp_hit_q, grp_hit_d;
  logic [SYM_W-1:0]  grp_pos_q [GROUPS];
  logic [SYM_W-1:0]  grp_pos_d [GROUPS];
  logic [SYM_W-1:0]  grp_val_q [GROUPS];
  logic [SYM_W-1:0]  grp_val_d [GROUPS];
  logic              found_q, found_d;
  logic [SYM_W-1:0]  pos_q, pos_d, held_q, held_d;

  // First level: OR the masked position and value inside each group
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    always_comb begin
      grp_hit_d[g] = 1'b0;
      grp_pos_d[g] = '0;
      grp_val_d[g] = '0;
      for (int unsigned j = 0; j < GROUP_SIZE; j++) begin
        if (hit_i[g*GROUP_SIZE+j]) begin
          grp_hit_d[g] = 1'b1;
          grp_pos_d[g] = grp_pos_d[g] | SYM_W'(g*GROUP_SIZE+j);
          grp_val_d[g] = grp_val_d[g] | value_i[g*GROUP_SIZE+j];
        end
      end
    end
  end

  // Second level: OR across the groups
  always_comb begin
    found_d = 1'b0;
    pos_d   = '0;
    held_d  = '0;
    for (int unsigned g = 0; g < GROUPS; g++) begin
      found_d = found_d | grp_hit_q[g];
      pos_d   = pos_d | grp_pos_q[g];
      held_d  = held_d | grp_val_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_hit_q <= grp_hit_d;
    grp_pos_q <= grp_pos_d;
    grp_val_q <= grp_val_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    held_q    <= held_d;
  end

  assign found_o = found_q;
  assign pos_o   = pos_q;
  assign held_o  = held_q;

endmodule
